// ----- src/asb_pkg.sv -----
// Shared constants and types for the ATA sector buffer interface.
package asb_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int POS_W        = $clog2(SECTOR_BYTES + 1);
    localparam int ADDR_W       = $clog2(SECTOR_BYTES);
    localparam int LBA_W        = 28;

    localparam logic [POS_W-1:0]  SECTOR_END = POS_W'(SECTOR_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(SECTOR_BYTES - 1);
    localparam logic [ADDR_W-1:0] ID_OFFSET  = ADDR_W'(114);

    // beat kinds on the input side
    localparam logic [1:0] ACT_BUS_READ  = 2'd0;
    localparam logic [1:0] ACT_BUS_WRITE = 2'd1;
    localparam logic [1:0] ACT_FILL      = 2'd2;
    localparam logic [1:0] ACT_DRAIN     = 2'd3;

    // media requests
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // task-file registers
    localparam logic [7:0] WINDOW_MASK = 8'he0;
    localparam logic [3:0] REG_DATA    = 4'h8;
    localparam logic [3:0] REG_LBA0    = 4'hb;
    localparam logic [3:0] REG_LBA1    = 4'hc;
    localparam logic [3:0] REG_LBA2    = 4'hd;
    localparam logic [3:0] REG_LBA3    = 4'he;
    localparam logic [3:0] REG_STATUS  = 4'hf;

    // commands
    localparam logic [7:0] CMD_READ        = 8'h20;
    localparam logic [7:0] CMD_WRITE       = 8'h30;
    localparam logic [7:0] CMD_IDENTIFY    = 8'hec;
    localparam logic [7:0] CMD_SET_FEATURE = 8'hef;

    // configuration register indexes
    localparam logic [1:0] CFG_PRESENT  = 2'd0;
    localparam logic [1:0] CFG_WRITABLE = 2'd1;
    localparam logic [1:0] CFG_WPROT    = 2'd2;
    localparam logic [1:0] CFG_BLOCKS   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WAIT  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

endpackage

// ----- src/ata_sector_buffer_interface.sv -----
// ATA task-file interface: register window, command decode and sector buffer.
//
// One beat in, one beat out. Register accesses, fills and buffer writes load the
// output register directly; data-port reads and drains pass through the wait
// state, since the buffer RAM has registered read data. A new beat is taken once
// the previous one has its result in the output register and that register is
// free or being taken. An identify command with a medium attached sweeps the
// whole buffer, writing zeros and the block count, and takes no beat meanwhile.
// Configuration writes are accepted in any cycle.
module ata_sector_buffer_interface_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[7:0], write_data[15:8], media_data[23:16],
                                   // media_ok[24], zero fill
    input  logic [1:0]  s_tuser,   // action[1:0]
    input  logic        s_tlast,   // media_last
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_data[7:0], media_lba[35:8], zero fill
    output logic [2:0]  m_tuser    // rom_select[0], media_request[2:1]
);

    localparam int POS_W  = asb_pkg::POS_W;
    localparam int ADDR_W = asb_pkg::ADDR_W;
    localparam int LBA_W  = asb_pkg::LBA_W;

    asb_pkg::state_t state_reg, state_next;

    logic [POS_W-1:0]  buf_pos_reg, buf_pos_next;
    logic [POS_W-1:0]  med_pos_reg, med_pos_next;
    logic [LBA_W-1:0]  lba_reg, lba_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic              err_reg, err_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic              present_reg, writable_reg, wprot_reg;
    logic [31:0]       blocks_reg;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_rom_reg, out_rom_next;
    logic [1:0]        out_req_reg, out_req_next;
    logic [LBA_W-1:0]  out_lba_reg, out_lba_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    logic              accept;
    logic [1:0]        action;
    logic [7:0]        address, wr_byte, med_byte;
    logic              med_ok, med_last;
    logic [3:0]        regsel;
    logic              in_window, wr_allowed;
    logic [7:0]        status;
    logic [31:0]       lba_wide;
    logic [ADDR_W-1:0] id_rel;
    logic [7:0]        clr_byte;

    assign action   = s_tuser;
    assign address  = s_tdata[7:0];
    assign wr_byte  = s_tdata[15:8];
    assign med_byte = s_tdata[23:16];
    assign med_ok   = s_tdata[24];
    assign med_last = s_tlast;

    assign regsel     = address[3:0];
    assign in_window  = (address & asb_pkg::WINDOW_MASK) == asb_pkg::WINDOW_MASK;
    assign wr_allowed = present_reg & writable_reg & ~wprot_reg;
    assign status     = {1'b0, 1'b1, 1'b0, 1'b1,
                         ~err_reg & (buf_pos_reg < asb_pkg::SECTOR_END), 2'b00, err_reg};
    assign lba_wide   = {{(32 - LBA_W){1'b0}}, lba_reg};

    assign s_tready = (state_reg == asb_pkg::ST_IDLE) & (~out_valid_reg | m_tready);
    assign accept   = s_tvalid & s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(40 - 8 - LBA_W){1'b0}}, out_lba_reg, out_data_reg};
    assign m_tuser  = {out_req_reg, out_rom_reg};

    // identify image: block count little-endian at the identify offset, zeros elsewhere
    assign id_rel = clr_cnt_reg - asb_pkg::ID_OFFSET;
    always_comb
    begin
        clr_byte = 8'h00;
        if (clr_cnt_reg >= asb_pkg::ID_OFFSET && id_rel < ADDR_W'(4))
        begin
            clr_byte = 8'(blocks_reg >> {id_rel[1:0], 3'b000});
        end
    end

    asb_ram #(
        .WIDTH (8),
        .DEPTH (asb_pkg::SECTOR_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic       load;
        logic [7:0] res_data;
        logic       res_rom;
        logic [1:0] res_req;

        load     = 1'b0;
        res_data = 8'h00;
        res_rom  = 1'b0;
        res_req  = asb_pkg::REQ_NONE;

        state_next   = state_reg;
        buf_pos_next = buf_pos_reg;
        med_pos_next = med_pos_reg;
        lba_next     = lba_reg;
        cmd_next     = cmd_reg;
        err_next     = err_reg;
        clr_cnt_next = clr_cnt_reg;

        ram_we    = 1'b0;
        ram_waddr = buf_pos_reg[ADDR_W-1:0];
        ram_wdata = wr_byte;
        ram_raddr = buf_pos_reg[ADDR_W-1:0];

        out_valid_next = out_valid_reg & ~m_tready;
        out_data_next  = out_data_reg;
        out_rom_next   = out_rom_reg;
        out_req_next   = out_req_reg;
        out_lba_next   = out_lba_reg;

        case (state_reg)
            asb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    case (action)
                        asb_pkg::ACT_BUS_READ:
                        begin
                            if (!in_window)
                            begin
                                res_rom = 1'b1;
                            end
                            else if (regsel == asb_pkg::REG_DATA)
                            begin
                                if (buf_pos_reg < asb_pkg::SECTOR_END)
                                begin
                                    buf_pos_next = buf_pos_reg + POS_W'(1);
                                    load         = 1'b0;
                                    state_next   = asb_pkg::ST_WAIT;
                                end
                            end
                            else if (regsel == asb_pkg::REG_LBA0 || regsel == asb_pkg::REG_LBA1
                                     || regsel == asb_pkg::REG_LBA2
                                     || regsel == asb_pkg::REG_LBA3)
                            begin
                                res_data = 8'(lba_wide >> {regsel - asb_pkg::REG_LBA0, 3'b000});
                            end
                            else if (regsel == asb_pkg::REG_STATUS)
                            begin
                                res_data = status;
                            end
                        end
                        asb_pkg::ACT_BUS_WRITE:
                        begin
                            if (!in_window)
                            begin
                                res_rom = 1'b1;
                            end
                            else
                            begin
                                case (regsel)
                                    asb_pkg::REG_DATA:
                                    begin
                                        if (buf_pos_reg < asb_pkg::SECTOR_END)
                                        begin
                                            ram_we       = 1'b1;
                                            buf_pos_next = buf_pos_reg + POS_W'(1);
                                            if (buf_pos_reg[ADDR_W-1:0] == asb_pkg::LAST_ENTRY
                                                && buf_pos_reg < asb_pkg::SECTOR_END
                                                && cmd_reg == asb_pkg::CMD_WRITE)
                                            begin
                                                if (wr_allowed)
                                                begin
                                                    res_req      = asb_pkg::REQ_WRITE;
                                                    med_pos_next = '0;
                                                end
                                                else
                                                begin
                                                    err_next = 1'b1;
                                                end
                                            end
                                        end
                                    end
                                    asb_pkg::REG_LBA0: lba_next[7:0]   = wr_byte;
                                    asb_pkg::REG_LBA1: lba_next[15:8]  = wr_byte;
                                    asb_pkg::REG_LBA2: lba_next[23:16] = wr_byte;
                                    asb_pkg::REG_LBA3: lba_next[27:24] = wr_byte[3:0];
                                    asb_pkg::REG_STATUS:
                                    begin
                                        cmd_next = wr_byte;
                                        case (wr_byte)
                                            asb_pkg::CMD_READ:
                                            begin
                                                buf_pos_next = '0;
                                                if (present_reg)
                                                begin
                                                    err_next     = 1'b0;
                                                    res_req      = asb_pkg::REQ_READ;
                                                    med_pos_next = '0;
                                                end
                                                else
                                                begin
                                                    err_next = 1'b1;
                                                end
                                            end
                                            asb_pkg::CMD_WRITE:
                                            begin
                                                buf_pos_next = '0;
                                                err_next     = ~wr_allowed;
                                            end
                                            asb_pkg::CMD_IDENTIFY:
                                            begin
                                                buf_pos_next = '0;
                                                if (present_reg)
                                                begin
                                                    err_next     = 1'b0;
                                                    clr_cnt_next = '0;
                                                    state_next   = asb_pkg::ST_CLEAR;
                                                end
                                                else
                                                begin
                                                    err_next = 1'b1;
                                                end
                                            end
                                            asb_pkg::CMD_SET_FEATURE:
                                            begin
                                                err_next = 1'b0;
                                            end
                                            default:
                                            begin
                                                err_next = 1'b1;
                                            end
                                        endcase
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                        asb_pkg::ACT_FILL:
                        begin
                            ram_waddr = med_pos_reg[ADDR_W-1:0];
                            ram_wdata = med_byte;
                            if (med_pos_reg < asb_pkg::SECTOR_END)
                            begin
                                ram_we       = 1'b1;
                                med_pos_next = med_pos_reg + POS_W'(1);
                            end
                            if (med_last)
                            begin
                                err_next     = ~med_ok;
                                med_pos_next = '0;
                            end
                        end
                        default:
                        begin
                            // drain
                            ram_raddr = med_pos_reg[ADDR_W-1:0];
                            if (med_pos_reg < asb_pkg::SECTOR_END)
                            begin
                                med_pos_next = med_pos_reg + POS_W'(1);
                                load         = 1'b0;
                                state_next   = asb_pkg::ST_WAIT;
                            end
                            if (med_last)
                            begin
                                err_next     = ~med_ok;
                                med_pos_next = '0;
                            end
                        end
                    endcase
                end
            end
            asb_pkg::ST_WAIT:
            begin
                // buffer byte arrives from the RAM this cycle
                load       = 1'b1;
                res_data   = ram_rdata;
                state_next = asb_pkg::ST_IDLE;
            end
            asb_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = clr_byte;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == asb_pkg::LAST_ENTRY)
                begin
                    state_next = asb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asb_pkg::ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
            out_rom_next   = res_rom;
            out_req_next   = res_req;
            out_lba_next   = (res_req != asb_pkg::REQ_NONE) ? lba_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asb_pkg::ST_IDLE;
            buf_pos_reg   <= '0;
            med_pos_reg   <= '0;
            lba_reg       <= '0;
            cmd_reg       <= '0;
            err_reg       <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_pos_reg   <= buf_pos_next;
            med_pos_reg   <= med_pos_next;
            lba_reg       <= lba_next;
            cmd_reg       <= cmd_next;
            err_reg       <= err_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_rom_reg  <= out_rom_next;
        out_req_reg  <= out_req_next;
        out_lba_reg  <= out_lba_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg  <= 1'b0;
            writable_reg <= 1'b0;
            wprot_reg    <= 1'b0;
            blocks_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                asb_pkg::CFG_PRESENT:  present_reg  <= cfg_wdata[0];
                asb_pkg::CFG_WRITABLE: writable_reg <= cfg_wdata[0];
                asb_pkg::CFG_WPROT:    wprot_reg    <= cfg_wdata[0];
                asb_pkg::CFG_BLOCKS:   blocks_reg   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- src/asb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module asb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking stream testbench for the ATA task-file sector buffer interface core.
module tb;

    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] address;
        logic [7:0] write_data;
        logic [7:0] media_data;
        logic       media_ok;
        logic       media_last;
    } beat_t;

    typedef struct packed {
        logic [7:0]                read_data;
        logic                      rom_select;
        logic [1:0]                media_request;
        logic [asb_pkg::LBA_W-1:0] media_lba;
    } reply_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    ata_sector_buffer_interface_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // task-file shadow state and card settings
    logic                      card_present;
    logic                      card_writable;
    logic                      card_wprot;
    logic [31:0]               card_blocks;
    logic [7:0]                sector_mem [asb_pkg::SECTOR_BYTES];
    int                        host_pos;
    int                        media_pos;
    logic [asb_pkg::LBA_W-1:0] lba_reg;
    logic [7:0]                cmd_reg;
    logic                      err_flag;

    reply_t due_replies [$];
    int     mismatches     = 0;
    int     beats_sent     = 0;
    int     quiet_cycles   = 0;
    int     src_idle_pct   = 0;
    int     sink_stall_pct = 0;
    int     hold_left      = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic writes_ok();
        return card_present && card_writable && !card_wprot;
    endfunction

    function automatic logic [7:0] status_now();
        logic drq;
        drq = !err_flag && (host_pos < asb_pkg::SECTOR_BYTES);
        return {1'b0, 1'b1, 1'b0, 1'b1, drq, 2'b00, err_flag};
    endfunction

    function automatic void end_transfer(beat_t b);
        if (b.media_last)
        begin
            err_flag  = !b.media_ok;
            media_pos = 0;
        end
    endfunction

    function automatic reply_t ata_predict(beat_t b);
        reply_t      r;
        logic [3:0]  rsel;
        logic        in_win;
        logic        is_lba;
        int          sh;
        logic [7:0]  v;
        logic [31:0] wide;
        r      = '0;
        rsel   = b.address[3:0];
        in_win = (b.address & asb_pkg::WINDOW_MASK) == asb_pkg::WINDOW_MASK;
        is_lba = (rsel >= asb_pkg::REG_LBA0) && (rsel <= asb_pkg::REG_LBA3);
        sh     = is_lba ? 8 * int'(rsel - asb_pkg::REG_LBA0) : 0;
        case (b.action)
            asb_pkg::ACT_BUS_READ:
            begin
                if (!in_win)
                    r.rom_select = 1'b1;
                else if (rsel == asb_pkg::REG_DATA)
                begin
                    if (host_pos < asb_pkg::SECTOR_BYTES)
                    begin
                        r.read_data = sector_mem[host_pos];
                        host_pos++;
                    end
                end
                else if (is_lba)
                    r.read_data = 8'({4'h0, lba_reg} >> sh);
                else if (rsel == asb_pkg::REG_STATUS)
                    r.read_data = status_now();
            end
            asb_pkg::ACT_BUS_WRITE:
            begin
                if (!in_win)
                    r.rom_select = 1'b1;
                else if (rsel == asb_pkg::REG_DATA)
                begin
                    if (host_pos < asb_pkg::SECTOR_BYTES)
                    begin
                        sector_mem[host_pos] = b.write_data;
                        host_pos++;
                        // last byte of a write command hands the sector to the medium
                        if (host_pos == asb_pkg::SECTOR_BYTES && cmd_reg == asb_pkg::CMD_WRITE)
                        begin
                            if (writes_ok())
                            begin
                                r.media_request = asb_pkg::REQ_WRITE;
                                media_pos       = 0;
                            end
                            else
                                err_flag = 1'b1;
                        end
                    end
                end
                else if (is_lba)
                begin
                    v       = (rsel == asb_pkg::REG_LBA3) ? {4'h0, b.write_data[3:0]}
                                                          : b.write_data;
                    wide    = {4'h0, lba_reg};
                    wide    = (wide & ~(32'hff << sh)) | (32'(v) << sh);
                    lba_reg = wide[asb_pkg::LBA_W-1:0];
                end
                else if (rsel == asb_pkg::REG_STATUS)
                begin
                    cmd_reg = b.write_data;
                    case (b.write_data)
                        asb_pkg::CMD_READ:
                        begin
                            host_pos = 0;
                            if (card_present)
                            begin
                                err_flag        = 1'b0;
                                r.media_request = asb_pkg::REQ_READ;
                                media_pos       = 0;
                            end
                            else
                                err_flag = 1'b1;
                        end
                        asb_pkg::CMD_WRITE:
                        begin
                            host_pos = 0;
                            err_flag = !writes_ok();
                        end
                        asb_pkg::CMD_IDENTIFY:
                        begin
                            host_pos = 0;
                            if (card_present)
                            begin
                                foreach (sector_mem[i])
                                    sector_mem[i] = 8'h00;
                                for (int k = 0; k < 4; k++)
                                    sector_mem[int'(asb_pkg::ID_OFFSET) + k] =
                                        card_blocks[8*k +: 8];
                                err_flag = 1'b0;
                            end
                            else
                                err_flag = 1'b1;
                        end
                        asb_pkg::CMD_SET_FEATURE:
                            err_flag = 1'b0;
                        default:
                            err_flag = 1'b1;
                    endcase
                end
            end
            asb_pkg::ACT_FILL:
            begin
                if (media_pos < asb_pkg::SECTOR_BYTES)
                begin
                    sector_mem[media_pos] = b.media_data;
                    media_pos++;
                end
                end_transfer(b);
            end
            default:
            begin
                // drain
                if (media_pos < asb_pkg::SECTOR_BYTES)
                begin
                    r.read_data = sector_mem[media_pos];
                    media_pos++;
                end
                end_transfer(b);
            end
        endcase
        if (r.media_request != asb_pkg::REQ_NONE)
            r.media_lba = lba_reg;
        return r;
    endfunction

    function automatic beat_t noise_beat();
        beat_t b;
        b.action     = 2'($urandom_range(3));
        b.address    = 8'($urandom);
        b.write_data = 8'($urandom);
        b.media_data = 8'($urandom);
        b.media_ok   = 1'($urandom);
        b.media_last = ($urandom_range(7) == 0);
        return b;
    endfunction

    function automatic beat_t bus_rd(input logic [7:0] a);
        beat_t b;
        b         = noise_beat();
        b.action  = asb_pkg::ACT_BUS_READ;
        b.address = a;
        return b;
    endfunction

    function automatic beat_t bus_wr(input logic [7:0] a, input logic [7:0] d);
        beat_t b;
        b            = noise_beat();
        b.action     = asb_pkg::ACT_BUS_WRITE;
        b.address    = a;
        b.write_data = d;
        return b;
    endfunction

    function automatic beat_t media_beat(input logic [1:0] act, input logic last,
                                         input logic ok);
        beat_t b;
        b            = noise_beat();
        b.action     = act;
        b.media_last = last;
        b.media_ok   = ok;
        return b;
    endfunction

    // bit 4 of the window address is a don't-care
    function automatic logic [7:0] tf_addr(input logic [3:0] rsel);
        return {3'b111, 1'($urandom_range(1)), rsel};
    endfunction

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic drive_beat(input beat_t b);
        int gap;
        gap = 0;
        while (src_idle_pct > 0 && gap < 16 && $urandom_range(99) < src_idle_pct)
            gap++;
        repeat (gap) @(negedge clk);
        s_tdata  = {7'd0, b.media_ok, b.media_data, b.write_data, b.address};
        s_tuser  = b.action;
        s_tlast  = b.media_last;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        due_replies.insert(due_replies.size(), ata_predict(b));
        beats_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic media_burst(input logic [1:0] act, input int len);
        for (int k = 0; k < len; k++)
            drive_beat(media_beat(act, k == len - 1, $urandom_range(3) != 0));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            asb_pkg::CFG_PRESENT:  card_present  = val[0];
            asb_pkg::CFG_WRITABLE: card_writable = val[0];
            asb_pkg::CFG_WPROT:    card_wprot    = val[0];
            asb_pkg::CFG_BLOCKS:   card_blocks   = val;
            default:
            begin
            end
        endcase
    endtask

    // wait out all replies plus a possible identify sweep
    task automatic settle();
        while (due_replies.size() != 0)
            @(negedge clk);
        repeat (asb_pkg::SECTOR_BYTES + 16) @(negedge clk);
    endtask

    task automatic apply_config(input logic present, input logic writable,
                                input logic wprot, input logic [31:0] blocks);
        settle();
        write_reg(asb_pkg::CFG_PRESENT, {31'd0, present});
        write_reg(asb_pkg::CFG_WRITABLE, {31'd0, writable});
        write_reg(asb_pkg::CFG_WPROT, {31'd0, wprot});
        write_reg(asb_pkg::CFG_BLOCKS, blocks);
    endtask

    task automatic set_idling(input int src, input int sink);
        src_idle_pct   = src;
        sink_stall_pct = sink;
    endtask

    task automatic test_registers();
        drive_beat(bus_rd(8'h00));
        drive_beat(bus_wr(8'hdf, 8'hff));
        drive_beat(bus_rd(8'hff));
        for (int k = 0; k < 4; k++)
            drive_beat(bus_wr(tf_addr(4'(asb_pkg::REG_LBA0 + 4'(k))), 8'hff));
        for (int k = 0; k < 4; k++)
            drive_beat(bus_rd(tf_addr(4'(asb_pkg::REG_LBA0 + 4'(k)))));
        drive_beat(bus_wr(tf_addr(4'h0), 8'h5a));
        drive_beat(bus_rd(tf_addr(4'h9)));
    endtask

    task automatic test_no_medium();
        logic [7:0] cmds [6];
        cmds = '{asb_pkg::CMD_READ, asb_pkg::CMD_WRITE, asb_pkg::CMD_IDENTIFY,
                 asb_pkg::CMD_SET_FEATURE, 8'h00, 8'hff};
        foreach (cmds[i])
        begin
            drive_beat(bus_wr(tf_addr(asb_pkg::REG_STATUS), cmds[i]));
            drive_beat(bus_rd(tf_addr(asb_pkg::REG_STATUS)));
        end
    endtask

    task automatic test_identify();
        apply_config(1'b1, 1'b1, 1'b0, 32'hffff_ffff);
        drive_beat(bus_wr(tf_addr(asb_pkg::REG_STATUS), asb_pkg::CMD_IDENTIFY));
        drive_beat(bus_rd(tf_addr(asb_pkg::REG_STATUS)));
        // start of the cleared image
        repeat (8) drive_beat(bus_rd(tf_addr(asb_pkg::REG_DATA)));
    endtask

    task automatic test_read_sector();
        drive_beat(bus_wr(tf_addr(asb_pkg::REG_LBA0), 8'h12));
        drive_beat(bus_wr(tf_addr(asb_pkg::REG_LBA1), 8'h34));
        drive_beat(bus_wr(tf_addr(asb_pkg::REG_LBA2), 8'h56));
        drive_beat(bus_wr(tf_addr(asb_pkg::REG_LBA3), 8'h7a));
        drive_beat(bus_wr(tf_addr(asb_pkg::REG_STATUS), asb_pkg::CMD_READ));
        drive_beat(media_beat(asb_pkg::ACT_FILL, 1'b0, 1'b1));
        drive_beat(media_beat(asb_pkg::ACT_FILL, 1'b0, 1'b1));
        drive_beat(media_beat(asb_pkg::ACT_FILL, 1'b1, 1'b0));
        drive_beat(bus_rd(tf_addr(asb_pkg::REG_STATUS)));
        drive_beat(media_beat(asb_pkg::ACT_FILL, 1'b1, 1'b1));
        drive_beat(bus_rd(tf_addr(asb_pkg::REG_DATA)));
        drive_beat(bus_rd(tf_addr(asb_pkg::REG_DATA)));
        drive_beat(media_beat(asb_pkg::ACT_DRAIN, 1'b0, 1'b1));
        drive_beat(media_beat(asb_pkg::ACT_DRAIN, 1'b1, 1'b1));
    endtask

    // receiver holds off while the sender keeps pushing
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_left = 300;
        repeat (20) drive_beat(bus_rd(tf_addr(4'($urandom_range(15)))));
    endtask

    // one full sector, stepping through the idling phases on the way
    task automatic test_full_sector();
        drive_beat(bus_wr(tf_addr(asb_pkg::REG_STATUS), asb_pkg::CMD_WRITE));
        for (int k = 0; k < asb_pkg::SECTOR_BYTES; k++)
        begin
            case (k / 128)
                0:       set_idling(0, 0);
                1:       set_idling(53, 0);
                2:       set_idling(0, 53);
                default: set_idling(12, 12);
            endcase
            drive_beat(bus_wr(tf_addr(asb_pkg::REG_DATA), 8'($urandom)));
        end
        // data port is exhausted now
        drive_beat(bus_wr(tf_addr(asb_pkg::REG_DATA), 8'h77));
        drive_beat(bus_rd(tf_addr(asb_pkg::REG_DATA)));
        drive_beat(bus_rd(tf_addr(asb_pkg::REG_STATUS)));
        media_burst(asb_pkg::ACT_DRAIN, 4);
        drive_beat(bus_rd(tf_addr(asb_pkg::REG_STATUS)));
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready = ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin : check_replies
        reply_t got;
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[7:0], m_tuser[0], m_tuser[2:1], m_tdata[35:8]};
            if (due_replies.size() == 0)
                note_error($sformatf("unexpected reply beat %h", got));
            else
            begin
                want = due_replies.pop_front();
                if (got.read_data !== want.read_data || got.rom_select !== want.rom_select
                    || got.media_request !== want.media_request
                    || got.media_lba !== want.media_lba)
                    note_error($sformatf({"reply mismatch (exp/got): data %h/%h rom %b/%b ",
                                          "req %0d/%0d lba %h/%h"},
                                         want.read_data, got.read_data,
                                         want.rom_select, got.rom_select,
                                         want.media_request, got.media_request,
                                         want.media_lba, got.media_lba));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL ata_sector_buffer_interface_core");
            $finish;
        end
    end

    initial
    begin
        card_present  = 1'b0;
        card_writable = 1'b0;
        card_wprot    = 1'b0;
        card_blocks   = '0;
        host_pos      = 0;
        media_pos     = 0;
        lba_reg       = '0;
        cmd_reg       = '0;
        err_flag      = 1'b0;
        foreach (sector_mem[i])
            sector_mem[i] = 8'h00;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_registers();
        test_no_medium();
        test_identify();
        test_read_sector();
        test_backpressure();
        test_full_sector();

        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);
        if (mismatches == 0 && due_replies.size() == 0)
            $display("PASS ata_sector_buffer_interface_core");
        else
            $display("FAIL ata_sector_buffer_interface_core");
        $finish;
    end

endmodule

// ----- sim.f -----
src/asb_pkg.sv
src/asb_ram.sv
src/ata_sector_buffer_interface.sv
verif/tb.sv
